>>> sv/pst_pkg.sv
// pst_pkg: shared types and constants for the priority spanning tree selector
// no dependencies
package pst_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_KP,
    ST_SORT_CHK,
    ST_SORT_NB,
    ST_SORT_CMP,
    ST_SCAN_RD,
    ST_SCAN_ID,
    ST_SCAN_BR,
    ST_FIND_P,
    ST_FIND_G,
    ST_JOIN_A,
    ST_JOIN_B,
    ST_EMIT
  } state_e;

  localparam int unsigned NodeDepth   = 32;
  localparam int unsigned BranchDepth = 64;
  localparam int unsigned PrioBits    = 8;
  localparam int unsigned NodeBits    = $clog2(NodeDepth);
  localparam int unsigned BranchBits  = $clog2(BranchDepth);
  localparam int unsigned CountBits   = $clog2(BranchDepth + 1);
  localparam int unsigned RankMax     = 7;
  localparam int unsigned RankBits    = 3;

endpackage

>>> sv/pst_ram.sv
// pst_ram: generic single write port, single read port ram with registered read
// no dependencies
module pst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/priority_spanning_tree_select_core.sv
// priority_spanning_tree_select_core: kruskal spanning tree selection over loaded branches
// depends on pst_pkg and pst_ram
//
// Branches load one per cycle into a branch memory while the core is in the load
// state; a branch with an endpoint at or above node_count, or beyond the 64
// stored, is dropped. The transfer marked last starts a run: the union-find
// memories are cleared, an insertion sort on a separate order memory orders the
// keys by shifting each one towards the front, then each branch is scanned with
// path-halving finds, and any output stall holds the scan. One result per stored
// branch follows in priority order (a single end-of-run result when none is
// stored); input is held off until the final result has been registered.
module priority_spanning_tree_select_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // from_node, to_node, priority_req, zero fill
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // valid_res, branch_index, in_tree, connected, tree_total
  output logic        m_axis_tlast    // end_of_run
);

  localparam int unsigned NB = pst_pkg::NodeBits;
  localparam int unsigned BB = pst_pkg::BranchBits;
  localparam int unsigned CB = pst_pkg::CountBits;
  localparam int unsigned RB = pst_pkg::RankBits;
  localparam int unsigned PW = pst_pkg::PrioBits;
  localparam int unsigned BW = 2 * NB + PW;

  pst_pkg::state_e state_q, state_d;

  logic [5:0]    node_count_q;
  logic [5:0]    eff_n;
  logic [5:0]    run_n_q, run_n_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [CB-1:0] i_q, i_d, j_q, j_d;
  logic [BB-1:0] key_q, key_d;
  logic [PW-1:0] kp_q, kp_d;
  logic [BB-1:0] id_q, id_d;
  logic [NB-1:0] x_q, x_d, ra_q, ra_d, b_q, b_d;
  logic          side_q, side_d;
  logic [RB-1:0] rka_q, rka_d;
  logic [NB-1:0] trees_q, trees_d;
  logic          in_tree_q, in_tree_d;
  logic [15:0]   out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          out_valid_q, out_valid_d;
  logic          conn;

  logic          br_we;
  logic [BB-1:0] br_waddr, br_raddr;
  logic [BW-1:0] br_wdata, br_rdata;
  logic          ord_we;
  logic [BB-1:0] ord_waddr, ord_raddr;
  logic [BB-1:0] ord_wdata, ord_rdata;
  logic          par_we;
  logic [NB-1:0] par_waddr, par_raddr;
  logic [NB-1:0] par_wdata, par_rdata;
  logic          rk_we;
  logic [NB-1:0] rk_waddr, rk_raddr;
  logic [RB-1:0] rk_wdata, rk_rdata;

  pst_ram #(.Width(BW), .Depth(pst_pkg::BranchDepth)) u_br (
    .clk_i, .we_i(br_we), .waddr_i(br_waddr), .wdata_i(br_wdata),
    .raddr_i(br_raddr), .rdata_o(br_rdata));
  pst_ram #(.Width(BB), .Depth(pst_pkg::BranchDepth)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata));
  pst_ram #(.Width(NB), .Depth(pst_pkg::NodeDepth)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .raddr_i(par_raddr), .rdata_o(par_rdata));
  pst_ram #(.Width(RB), .Depth(pst_pkg::NodeDepth)) u_rank (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rk_wdata),
    .raddr_i(rk_raddr), .rdata_o(rk_rdata));

  logic [NB-1:0] in_from, in_to;
  logic [PW-1:0] in_prio;
  logic [NB-1:0] br_from, br_to;
  logic [PW-1:0] br_prio;
  logic          take;

  assign in_from = s_axis_tdata[4:0];
  assign in_to   = s_axis_tdata[9:5];
  assign in_prio = s_axis_tdata[17:10];
  assign br_from = br_rdata[NB-1:0];
  assign br_to   = br_rdata[2*NB-1:NB];
  assign br_prio = br_rdata[BW-1:2*NB];
  assign eff_n   = (node_count_q < 6'(pst_pkg::NodeDepth)) ? node_count_q
                                                           : 6'(pst_pkg::NodeDepth);
  assign take    = s_axis_tvalid && s_axis_tready;
  assign conn    = (run_n_q >= 6'd1) && ({1'b0, trees_q} == run_n_q - 6'd1);

  assign s_axis_tready = (state_q == pst_pkg::ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pst_pkg::ST_LOAD;
      node_count_q <= 6'd1;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; key_q <= key_d; kp_q <= kp_d; id_q <= id_d;
    x_q <= x_d; ra_q <= ra_d; b_q <= b_d; side_q <= side_d; rka_q <= rka_d;
    trees_q <= trees_d; run_n_q <= run_n_d; in_tree_q <= in_tree_d;
    out_data_q <= out_data_d; out_last_q <= out_last_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    i_d = i_q; j_d = j_q; key_d = key_q; kp_d = kp_q; id_d = id_q;
    x_d = x_q; ra_d = ra_q; b_d = b_q; side_d = side_q; rka_d = rka_q;
    trees_d = trees_q; run_n_d = run_n_q; in_tree_d = in_tree_q;
    out_data_d = out_data_q; out_last_d = out_last_q; out_valid_d = out_valid_q;
    br_we = 1'b0; br_waddr = cnt_q[BB-1:0]; br_raddr = '0;
    br_wdata = {in_prio, in_to, in_from};
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_raddr = '0;
    rk_we = 1'b0; rk_waddr = '0; rk_wdata = '0; rk_raddr = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pst_pkg::ST_LOAD: begin
        if (take) begin
          if ({1'b0, in_from} < eff_n && {1'b0, in_to} < eff_n &&
              cnt_q < CB'(pst_pkg::BranchDepth)) begin
            br_we     = 1'b1;
            ord_we    = 1'b1;
            ord_waddr = cnt_q[BB-1:0];
            ord_wdata = cnt_q[BB-1:0];
            cnt_d     = cnt_q + 1'b1;
          end
          if (s_axis_tlast) begin
            run_n_d = eff_n;
            x_d     = '0;
            state_d = pst_pkg::ST_CLR;
          end
        end
      end
      pst_pkg::ST_CLR: begin
        par_we = 1'b1; par_waddr = x_q; par_wdata = x_q;
        rk_we = 1'b1; rk_waddr = x_q; rk_wdata = '0;
        x_d = x_q + 1'b1;
        if (x_q == NB'(pst_pkg::NodeDepth - 1)) begin
          i_d = CB'(1);
          state_d = pst_pkg::ST_SORT_RD;
        end
      end
      pst_pkg::ST_SORT_RD: begin
        if (i_q >= cnt_q) begin
          i_d = '0; trees_d = '0;
          state_d = (cnt_q == '0) ? pst_pkg::ST_EMIT : pst_pkg::ST_SCAN_RD;
        end else begin
          ord_raddr = i_q[BB-1:0];
          j_d = i_q;
          state_d = pst_pkg::ST_SORT_KEY;
        end
      end
      pst_pkg::ST_SORT_KEY: begin
        key_d = ord_rdata; br_raddr = ord_rdata;
        state_d = pst_pkg::ST_SORT_KP;
      end
      pst_pkg::ST_SORT_KP: begin
        kp_d = br_prio;
        state_d = pst_pkg::ST_SORT_CHK;
      end
      pst_pkg::ST_SORT_CHK: begin
        if (j_q == '0) begin
          ord_we = 1'b1; ord_waddr = '0; ord_wdata = key_q;
          i_d = i_q + 1'b1;
          state_d = pst_pkg::ST_SORT_RD;
        end else begin
          ord_raddr = BB'(j_q - 1'b1);
          state_d = pst_pkg::ST_SORT_NB;
        end
      end
      pst_pkg::ST_SORT_NB: begin
        id_d = ord_rdata; br_raddr = ord_rdata;
        state_d = pst_pkg::ST_SORT_CMP;
      end
      pst_pkg::ST_SORT_CMP: begin
        ord_we = 1'b1; ord_waddr = j_q[BB-1:0];
        if (br_prio < kp_q) begin
          ord_wdata = id_q;
          j_d = j_q - 1'b1;
          state_d = pst_pkg::ST_SORT_CHK;
        end else begin
          ord_wdata = key_q;
          i_d = i_q + 1'b1;
          state_d = pst_pkg::ST_SORT_RD;
        end
      end
      pst_pkg::ST_SCAN_RD: begin
        ord_raddr = i_q[BB-1:0];
        state_d = pst_pkg::ST_SCAN_ID;
      end
      pst_pkg::ST_SCAN_ID: begin
        id_d = ord_rdata; br_raddr = ord_rdata;
        state_d = pst_pkg::ST_SCAN_BR;
      end
      pst_pkg::ST_SCAN_BR: begin
        b_d = br_to; x_d = br_from; par_raddr = br_from; side_d = 1'b0;
        state_d = pst_pkg::ST_FIND_P;
      end
      pst_pkg::ST_FIND_P: begin
        // parent of x on the read port
        if (par_rdata == x_q) begin
          if (!side_q) begin
            ra_d = x_q; x_d = b_q; par_raddr = b_q; side_d = 1'b1;
          end else begin
            b_d = x_q; rk_raddr = ra_q;
            state_d = pst_pkg::ST_JOIN_A;
          end
        end else begin
          par_raddr = par_rdata;
          state_d = pst_pkg::ST_FIND_G;
        end
      end
      pst_pkg::ST_FIND_G: begin
        // grandparent on the read port: halve the path
        par_we = 1'b1; par_waddr = x_q; par_wdata = par_rdata;
        x_d = par_rdata; par_raddr = par_rdata;
        state_d = pst_pkg::ST_FIND_P;
      end
      pst_pkg::ST_JOIN_A: begin
        rka_d = rk_rdata; rk_raddr = b_q;
        state_d = pst_pkg::ST_JOIN_B;
      end
      pst_pkg::ST_JOIN_B: begin
        in_tree_d = (ra_q != b_q);
        if (ra_q != b_q) begin
          trees_d = trees_q + 1'b1;
          par_we = 1'b1;
          if (rka_q < rk_rdata) begin
            par_waddr = ra_q; par_wdata = b_q;
          end else begin
            par_waddr = b_q; par_wdata = ra_q;
            if (rka_q == rk_rdata && rka_q < RB'(pst_pkg::RankMax)) begin
              rk_we = 1'b1; rk_waddr = ra_q; rk_wdata = rka_q + 1'b1;
            end
          end
        end
        state_d = pst_pkg::ST_EMIT;
      end
      pst_pkg::ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (cnt_q == '0) begin
            out_last_d = 1'b1;
            out_data_d = 16'({5'd0, (run_n_q == 6'd1), 1'b0, 6'd0, 1'b0});
            state_d = pst_pkg::ST_LOAD;
          end else if (i_q + 1'b1 == cnt_q) begin
            out_last_d = 1'b1;
            out_data_d = 16'({trees_q, conn, in_tree_q, id_q, 1'b1});
            cnt_d = '0;
            state_d = pst_pkg::ST_LOAD;
          end else begin
            out_last_d = 1'b0;
            out_data_d = 16'({5'd0, 1'b0, in_tree_q, id_q, 1'b1});
            i_d = i_q + 1'b1;
            state_d = pst_pkg::ST_SCAN_RD;
          end
        end
      end
      default: state_d = pst_pkg::ST_LOAD;
    endcase
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while waiting");
  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pst_pkg::ST_LOAD) |-> !s_axis_tready)
    else $error("input accepted during run");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(pst_pkg::BranchDepth))
    else $error("branch count overflow");

endmodule
